>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define SLR_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define SLR_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("assertion failed");

// next-cycle implication, also checked across reset
`define SLR_ASSERT_RST(lbl, ant, con) \
  lbl: assert property (@(posedge clk) (ant) |=> (con)) \
    else $error("assertion failed");

`endif

>>> rtl/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg
// shared types and constants of the literal search and replace block
// ----------------------------------------------------------------------------
`default_nettype none

package slr_pkg;

  localparam int JOB_BYTES       = 16;
  localparam int COUNT_W         = $clog2(JOB_BYTES + 1);
  localparam int QUEUE_DEPTH     = 2;
  localparam int MAX_PATTERN_DEF = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW     = 3'd0,
    REG_PATTERN_HIGH    = 3'd1,
    REG_PATTERN_LENGTH  = 3'd2,
    REG_REPLACE_LOW     = 3'd3,
    REG_REPLACE_HIGH    = 3'd4,
    REG_REPLACE_LENGTH  = 3'd5,
    REG_REPLACE_ALL     = 3'd6
  } cfg_reg_t;

  // one unit of work for the output side: up to JOB_BYTES bytes, byte 0 first
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [COUNT_W-1:0]        count;
    logic                      stream_end;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/slr_front.sv
// ----------------------------------------------------------------------------
// slr_front
// configuration registers, match window and classification of input beats
// ----------------------------------------------------------------------------
`default_nettype none

module slr_front #(
  parameter int MAX_PATTERN = slr_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [slr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [slr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      in_byte,
  input  wire logic                            in_end,
  input  wire logic                            queue_full,
  output logic                                 job_push,
  output slr_pkg::job_t                        job
);

  localparam int JB      = slr_pkg::JOB_BYTES;
  localparam int CW      = slr_pkg::COUNT_W;
  localparam int WIN_CAP = (MAX_PATTERN < JB) ? MAX_PATTERN : JB;
  localparam int FILL_W  = $clog2(WIN_CAP + 1);

  logic [63:0]       pat_lo_r, pat_hi_r, rep_lo_r, rep_hi_r;
  logic [4:0]        pat_len_r, rep_len_r;
  logic              rall_r;
  logic [7:0]        win_r [WIN_CAP];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              first_r, first_nxt;

  logic [7:0]          win_ext [JB+1];
  logic [7:0]          lst [JB+1];
  logic [JB-1:0][7:0]  pat_b, rep_b;
  logic [FILL_W-1:0]   len;
  logic [CW-1:0]       rlen;
  logic [FILL_W:0]     fill_inc;
  logic                accept, pass, full, match, hit;

  assign in_ready = !queue_full;
  assign accept   = in_valid && !queue_full;
  assign pat_b    = {pat_hi_r, pat_lo_r};
  assign rep_b    = {rep_hi_r, rep_lo_r};

  for (genvar gi = 0; gi <= JB; gi++) begin : g_ext
    if (gi < WIN_CAP) begin : g_on
      assign win_ext[gi] = win_r[gi];
    end else begin : g_off
      assign win_ext[gi] = 8'h00;
    end
  end

  always_comb begin
    len      = (pat_len_r > 5'(WIN_CAP)) ? FILL_W'(WIN_CAP) : FILL_W'(pat_len_r);
    rlen     = (rep_len_r > 5'(JB)) ? CW'(JB) : CW'(rep_len_r);
    fill_inc = {1'b0, fill_r} + 1'b1;
    full     = (fill_inc == {1'b0, len});
    pass     = (len == '0) || (!rall_r && first_r);
    // window contents with the new byte appended
    for (int i = 0; i <= JB; i++) begin
      if (i < int'(fill_r)) begin
        lst[i] = win_ext[i];
      end else if (i == int'(fill_r)) begin
        lst[i] = in_byte;
      end else begin
        lst[i] = 8'h00;
      end
    end
    match = 1'b1;
    for (int i = 0; i < JB; i++) begin
      if ((i < int'(len)) && (lst[i] != pat_b[i])) begin
        match = 1'b0;
      end
    end
    hit = !pass && full && match;

    job.stream_end = in_end;
    for (int i = 0; i < JB; i++) begin
      job.bytes[i] = lst[i];
    end
    if (hit) begin
      job.bytes = rep_b;
      job.count = rlen;
    end else if (pass || in_end) begin
      job.count = CW'(fill_inc);
    end else if (full) begin
      job.count = CW'(1);
    end else begin
      job.count = '0;
    end
    job_push = accept && (job.count != '0);

    if (in_end || pass || hit) begin
      fill_nxt = '0;
    end else if (full) begin
      fill_nxt = fill_r;
    end else begin
      fill_nxt = fill_inc[FILL_W-1:0];
    end
    first_nxt = in_end ? 1'b0 : (hit ? 1'b1 : first_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      rep_lo_r  <= '0;
      rep_hi_r  <= '0;
      pat_len_r <= '0;
      rep_len_r <= '0;
      rall_r    <= 1'b0;
      fill_r    <= '0;
      first_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (slr_pkg::cfg_reg_t'(cfg_index))
        slr_pkg::REG_PATTERN_LOW:    pat_lo_r <= cfg_wdata;
        slr_pkg::REG_PATTERN_HIGH:   pat_hi_r <= cfg_wdata;
        slr_pkg::REG_PATTERN_LENGTH: begin
          pat_len_r <= cfg_wdata[4:0];
          fill_r    <= '0;
        end
        slr_pkg::REG_REPLACE_LOW:    rep_lo_r <= cfg_wdata;
        slr_pkg::REG_REPLACE_HIGH:   rep_hi_r <= cfg_wdata;
        slr_pkg::REG_REPLACE_LENGTH: rep_len_r <= cfg_wdata[4:0];
        slr_pkg::REG_REPLACE_ALL:    rall_r <= cfg_wdata[0];
        default: ;
      endcase
    end else if (accept) begin
      fill_r  <= fill_nxt;
      first_r <= first_nxt;
    end
  end

  // window bytes, shifted by one on a full window without a match
  always_ff @(posedge clk) begin
    if (accept && !pass && !in_end && !hit) begin
      for (int i = 0; i < WIN_CAP; i++) begin
        win_r[i] <= full ? lst[i+1] : lst[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/slr_queue.sv
// ----------------------------------------------------------------------------
// slr_queue
// short job queue between the classifying front and the output side
// ----------------------------------------------------------------------------
`default_nettype none

module slr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  slr_pkg::job_t       push_job,
  output logic                full,
  input  wire logic           pop,
  output slr_pkg::job_t       head_job,
  output logic                head_valid
);

  localparam int DEPTH = slr_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  slr_pkg::job_t ent_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] cnt_r;

  assign full       = (cnt_r == NW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

>>> rtl/slr_back.sv
// ----------------------------------------------------------------------------
// slr_back
// expands queued jobs into output beats through a registered output stage
// ----------------------------------------------------------------------------
`default_nettype none

module slr_back (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  slr_pkg::job_t   head_job,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_done
);

  localparam int JB = slr_pkg::JOB_BYTES;
  localparam int CW = slr_pkg::COUNT_W;

  logic [JB-1:0][7:0] sh_r;
  logic [CW-1:0]      left_r;
  logic               end_r;
  logic               out_valid_r, out_last_r, out_done_r;
  logic [7:0]         out_byte_r;
  logic               busy, load, final_byte;

  assign busy       = (left_r != '0);
  assign load       = busy && (!out_valid_r || out_ready);
  assign final_byte = (left_r == CW'(1));
  assign pop        = head_valid && (!busy || (load && final_byte));

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_done  = out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        left_r <= head_job.count;
      end else if (load) begin
        left_r <= left_r - 1'b1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sh_r  <= head_job.bytes;
      end_r <= head_job.stream_end;
    end else if (load) begin
      sh_r <= {8'h00, sh_r[JB-1:1]};
    end
    if (load) begin
      out_byte_r <= sh_r[0];
      out_last_r <= final_byte;
      out_done_r <= final_byte && end_r;
    end
  end

endmodule

`default_nettype wire

>>> rtl/stream_literal_replace.sv
// ----------------------------------------------------------------------------
// stream_literal_replace
// literal search and replace on a byte stream
// ----------------------------------------------------------------------------
// An input beat is taken whenever the two-entry job queue has room, and the
// window compare against the pattern is done in the cycle it is taken. The
// output side emits one byte per cycle unless out_tready stalls it, so a beat
// that yields n bytes (a replacement or an end-of-stream flush) keeps the
// output side busy for n bytes and input backs up once the queue is full;
// beats yielding one or no byte flow at one per cycle while unstalled. Results
// pass the job queue, the shift register and the output register. No start-up sweep follows reset.
`default_nettype none

module stream_literal_replace #(
  parameter int MAX_PATTERN = slr_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [slr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [slr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,   // in_byte
  input  wire logic                            in_tlast,   // stream_end
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [7:0]                           out_tdata,  // out_byte
  output logic                                 out_tlast,  // run_last
  output logic [0:0]                           out_tuser   // stream_done
);

  slr_pkg::job_t push_job, head_job;
  logic          job_push, queue_full, head_valid, pop, out_done;

  slr_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_end     (in_tlast),
    .queue_full (queue_full),
    .job_push   (job_push),
    .job        (push_job)
  );

  slr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_job   (head_job),
    .head_valid (head_valid)
  );

  slr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .out_done   (out_done)
  );

  assign out_tuser = out_done;

endmodule

`default_nettype wire

>>> rtl/slr_checker.sv
// ----------------------------------------------------------------------------
// slr_checker
// port-level checks on the literal search and replace block
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module slr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic [0:0] out_tuser
);

  // a stalled beat stays offered
  `SLR_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  // a stalled beat keeps its payload
  `SLR_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready,
    $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
  // the end of a stream always closes a run
  `SLR_ASSERT_IMP(a_done_last, out_tvalid && out_tuser[0], out_tlast)
  // reset empties the queue and the output stage
  `SLR_ASSERT_RST(a_reset_clear, !rst_n, !out_tvalid && in_tready)

endmodule

bind stream_literal_replace slr_checker u_slr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
